### hdl/b2da_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
`timescale 1ns / 1ps
package b2da_pkg;
  localparam int IN_WIDTH    = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int NUM_DIGITS  = 20;
  localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int REM_W       = $clog2(NUM_DIGITS + 1);
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);
  localparam int CHAR_W      = 6;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

  typedef logic [BCD_WIDTH-1:0] bcd_t;
  typedef logic [CHAR_W-1:0] char_t;
endpackage

### hdl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Conversion: a bit-serial double dabble loop converts each value, then hands the
// BCD word to the queue, waiting while the queue is full, before it takes a new value.
// Output: after leading zeros are dropped, one digit per cycle while the consumer keeps popping.
// Reset: synchronous on rst; clears both parts and the queue, no pending digits.
`timescale 1ns / 1ps
module binary_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [b2da_pkg::IN_WIDTH-1:0] value,
  output logic                          empty,
  input  logic                          pop,
  output b2da_pkg::char_t               digit_char,
  output logic                          last_digit
);
  import b2da_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  bcd_t q_wr_data;
  bcd_t q_rd_data;

  b2da_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .value  (value),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wr_data)
  );

  b2da_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  b2da_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .q_pop      (q_pop),
    .q_empty    (q_empty),
    .q_data     (q_rd_data),
    .empty      (empty),
    .pop        (pop),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );
endmodule

### hdl/b2da_conv.sv
// Front part: accepts a binary value and converts it to packed BCD, one bit per cycle.
`timescale 1ns / 1ps
module b2da_conv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [b2da_pkg::IN_WIDTH-1:0] value,
  output logic                          q_push,
  input  logic                          q_full,
  output b2da_pkg::bcd_t                q_data
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] shreg;
  bcd_t                   bcd;
  bcd_t                   bcd_adj;
  logic [CNT_W-1:0]       count;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign full   = (state != ST_IDLE);
  assign q_push = (state == ST_DONE) && !q_full;
  assign q_data = bcd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (push) begin
            shreg <= value[VALUE_WIDTH-1:0];
            bcd   <= '0;
            count <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          bcd   <= {bcd_adj[BCD_WIDTH-2:0], shreg[VALUE_WIDTH-1]};
          shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
          count <= count + 1'b1;
          if (count == CNT_W'(VALUE_WIDTH - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

### hdl/b2da_fifo.sv
// Short queue of converted BCD words between the front and back parts.
`timescale 1ns / 1ps
module b2da_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  b2da_pkg::bcd_t wr_data,
  input  logic           pop,
  output logic           empty,
  output b2da_pkg::bcd_t rd_data
);
  import b2da_pkg::*;

  bcd_t              entries [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == FILL_W'(FIFO_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

### hdl/b2da_emit.sv
// Back part: drops leading zeros and sends one ASCII digit per beat.
`timescale 1ns / 1ps
module b2da_emit (
  input  logic                    clk,
  input  logic                    rst,
  output logic                    q_pop,
  input  logic                    q_empty,
  input  b2da_pkg::bcd_t          q_data,
  output logic                    empty,
  input  logic                    pop,
  output b2da_pkg::char_t         digit_char,
  output logic                    last_digit
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  bcd_t             sr;
  logic [REM_W-1:0] remain;
  logic             out_valid;
  logic [3:0]       top;
  logic             slot_free;
  logic             emit_fire;

  assign top       = sr[BCD_WIDTH-1 -: 4];
  assign slot_free = !out_valid || pop;
  assign emit_fire = (state == ST_EMIT) && slot_free;
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      remain    <= '0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            sr     <= q_data;
            remain <= REM_W'(NUM_DIGITS);
            state  <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (top == 4'd0 && remain != REM_W'(1)) begin
            sr     <= {sr[BCD_WIDTH-5:0], 4'd0};
            remain <= remain - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            digit_char <= DIGIT_BASE + {2'b00, top};
            last_digit <= (remain == REM_W'(1));
            sr         <= {sr[BCD_WIDTH-5:0], 4'd0};
            remain     <= remain - 1'b1;
            if (remain == REM_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule
